// ===== rtl/e2rm_pkg.sv =====
// ----------------------------------------------------------------------------
// e2rm_pkg: shared constants for the Euler angle to rotation matrix core
// Fixed-point constants in Q.30, the CORDIC arctangent table, and the
// rounding product helper used by the matrix stages.
// ----------------------------------------------------------------------------
package e2rm_pkg;

	localparam int FRAC = 30;
	localparam int WW   = 36;      // internal word: sign, integer headroom, 30 fraction bits

	typedef logic signed [WW-1:0] word_t;

	localparam word_t Q_PI      = 36'sd3373259426;
	localparam word_t Q_HALF_PI = 36'sd1686629713;
	localparam word_t Q_TWO_PI  = 36'sd6746518852;
	localparam word_t Q_GAIN    = 36'sd652032874;
	localparam word_t Q_RND     = 36'sd536870912;

	// arctangent of 2^-i in Q.30
	function automatic word_t atan_q30(input int i);
		word_t r;
		case (i)
			0:  r = 36'sd843314857;
			1:  r = 36'sd497837829;
			2:  r = 36'sd263043837;
			3:  r = 36'sd133525159;
			4:  r = 36'sd67021687;
			5:  r = 36'sd33543516;
			6:  r = 36'sd16775851;
			7:  r = 36'sd8388437;
			8:  r = 36'sd4194283;
			9:  r = 36'sd2097149;
			default: r = (i < 31) ? word_t'(36'sd1 <<< (30 - i)) : '0;
		endcase
		return r;
	endfunction

	// round a full product of two Q.30 values back to Q.30, half up
	function automatic word_t qround(input logic signed [2*WW-1:0] p);
		logic signed [2*WW-1:0] t;
		t = p + (2*WW)'(Q_RND);
		return word_t'(t >>> FRAC);
	endfunction

endpackage

// ===== rtl/e2rm_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// e2rm_cordic_cell: one rotation-mode CORDIC micro-rotation
// Holds x, y, z for three angles and passes them on each cycle that en is high.
// ----------------------------------------------------------------------------
module e2rm_cordic_cell import e2rm_pkg::*; #(
	parameter int SHIFT = 0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        vin,
	input  word_t       xin [3],
	input  word_t       yin [3],
	input  word_t       zin [3],
	input  logic [2:0]  nin,
	output logic        vout,
	output word_t       xout [3],
	output word_t       yout [3],
	output word_t       zout [3],
	output logic [2:0]  nout
);

	localparam word_t ATAN = atan_q30(SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else if (en) begin
			vout <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nout <= nin;
			for (int k = 0; k < 3; k++) begin
				if (!zin[k][WW-1]) begin
					xout[k] <= xin[k] - (yin[k] >>> SHIFT);
					yout[k] <= yin[k] + (xin[k] >>> SHIFT);
					zout[k] <= zin[k] - ATAN;
				end else begin
					xout[k] <= xin[k] + (yin[k] >>> SHIFT);
					yout[k] <= yin[k] - (xin[k] >>> SHIFT);
					zout[k] <= zin[k] + ATAN;
				end
			end
		end
	end

endmodule

// ===== rtl/euler_to_rotation_matrix_core.sv =====
// Euler angle to Z-Y-X rotation matrix. One angle triple is taken per cycle
// while the pipe is not stalled; the stages are one reduction stage, a chain of
// CORDIC_STAGES micro-rotation cells, three product stages and one rounding
// stage. The whole pipe advances when the output register is empty or taken.
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix_core: top level
// Angle folding, CORDIC cell chain, matrix products and saturation.
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix_core import e2rm_pkg::*; #(
	parameter int ANGLE_WIDTH   = 16,
	parameter int COEF_WIDTH    = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// yaw_angle, pitch_angle, roll_angle from the lowest bit up
	input  logic [((3*ANGLE_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// r11, r12, r10, r21, r22, r20, r01, r02, r00 from the lowest bit up
	output logic [((9*COEF_WIDTH+7)/8)*8-1:0]  m_tdata
);

	localparam int N  = CORDIC_STAGES;
	localparam int PW = 2*WW;
	localparam int SH = FRAC - (COEF_WIDTH - 2);

	logic en;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	// stage 1: scale, reduce, fold
	word_t      z_s1 [3];
	logic [2:0] n_s1;
	logic       v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				word_t t;
				logic  fold;
				t = word_t'($signed(s_tdata[k*ANGLE_WIDTH +: ANGLE_WIDTH]))
					<<< (FRAC - (ANGLE_WIDTH - 4));
				if (t > Q_PI) t = t - Q_TWO_PI;
				if (t > Q_PI) t = t - Q_TWO_PI;
				if (t < -Q_PI) t = t + Q_TWO_PI;
				if (t < -Q_PI) t = t + Q_TWO_PI;
				fold = 1'b0;
				if (t > Q_HALF_PI) begin
					t = Q_PI - t;
					fold = 1'b1;
				end else if (t < -Q_HALF_PI) begin
					t = -Q_PI - t;
					fold = 1'b1;
				end
				n_s1[k] <= fold;
				z_s1[k] <= t;
			end
		end
	end

	// CORDIC cell chain
	word_t      cx [N+1][3];
	word_t      cy [N+1][3];
	word_t      cz [N+1][3];
	logic [2:0] cn [N+1];
	logic       cv [N+1];

	assign cv[0] = v_s1;
	assign cn[0] = n_s1;
	for (genvar k = 0; k < 3; k++) begin : g_init
		assign cx[0][k] = Q_GAIN;
		assign cy[0][k] = '0;
		assign cz[0][k] = z_s1[k];
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		e2rm_cordic_cell #(.SHIFT(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vin(cv[i]), .xin(cx[i]), .yin(cy[i]), .zin(cz[i]), .nin(cn[i]),
			.vout(cv[i+1]), .xout(cx[i+1]), .yout(cy[i+1]), .zout(cz[i+1]),
			.nout(cn[i+1])
		);
	end

	word_t s [3];
	word_t c [3];
	for (genvar k = 0; k < 3; k++) begin : g_sc
		assign s[k] = cy[N][k];
		assign c[k] = cn[N][k] ? -cx[N][k] : cx[N][k];
	end

	// sines, cosines and their products stay within plus or minus two in Q.30,
	// so 32 bits carry each operand exactly
	function automatic word_t qm(input word_t a, input word_t b);
		logic signed [63:0] p;
		p = 64'($signed(a[31:0])) * 64'($signed(b[31:0]));
		return qround(PW'(p));
	endfunction

	// product stage A: pairwise products (0 yaw, 1 pitch, 2 roll)
	word_t cycr_a, sysp_a, cysr_a, sycr_a, cysp_a, sycp_a, cpsr_a, cpcr_a, cycp_a, srsy_a;
	word_t sp_a, sr_a, cr_a;
	logic  v_a;
	// stage B: triple products
	word_t t0_b, t1_b, t6_b, t7_b;
	word_t cycr_b, cysr_b, sycr_b, srsy_b, sycp_b, cpsr_b, cpcr_b, cycp_b, sp_b;
	logic  v_b;
	// stage C: sums
	word_t e_c [9];
	logic  v_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_a <= 1'b0; v_b <= 1'b0; v_c <= 1'b0; m_tvalid <= 1'b0;
		end else if (en) begin
			v_a <= cv[N]; v_b <= v_a; v_c <= v_b; m_tvalid <= v_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cycr_a <= qm(c[0], c[2]);
			sysp_a <= qm(s[0], s[1]);
			cysr_a <= qm(c[0], s[2]);
			sycr_a <= qm(s[0], c[2]);
			cysp_a <= qm(c[0], s[1]);
			sycp_a <= qm(s[0], c[1]);
			cpsr_a <= qm(c[1], s[2]);
			cpcr_a <= qm(c[1], c[2]);
			cycp_a <= qm(c[0], c[1]);
			srsy_a <= qm(s[2], s[0]);
			sp_a   <= s[1];
			sr_a   <= s[2];
			cr_a   <= c[2];

			t0_b   <= qm(sysp_a, sr_a);
			t1_b   <= qm(sysp_a, cr_a);
			t6_b   <= qm(cysp_a, sr_a);
			t7_b   <= qm(cycr_a, sp_a);
			cycr_b <= cycr_a; cysr_b <= cysr_a; sycr_b <= sycr_a; srsy_b <= srsy_a;
			sycp_b <= sycp_a; cpsr_b <= cpsr_a; cpcr_b <= cpcr_a; cycp_b <= cycp_a;
			sp_b   <= sp_a;

			e_c[0] <= cycr_b + t0_b;
			e_c[1] <= t1_b - cysr_b;
			e_c[2] <= sycp_b;
			e_c[3] <= cpsr_b;
			e_c[4] <= cpcr_b;
			e_c[5] <= -sp_b;
			e_c[6] <= t6_b - sycr_b;
			e_c[7] <= srsy_b + t7_b;
			e_c[8] <= cycp_b;
		end
	end

	// round to coefficient format and clamp to plus or minus one
	localparam word_t ONE = word_t'(1) <<< (COEF_WIDTH - 2);

	always_ff @(posedge clk) begin
		if (en) begin
			logic [$bits(m_tdata)-1:0] d;
			d = '0;
			for (int k = 0; k < 9; k++) begin
				word_t r;
				r = e_c[k];
				if (SH > 0) r = (e_c[k] + (word_t'(1) <<< (SH - 1))) >>> SH;
				if (r > ONE) r = ONE;
				if (r < -ONE) r = -ONE;
				d[k*COEF_WIDTH +: COEF_WIDTH] = r[COEF_WIDTH-1:0];
			end
			m_tdata <= d;
		end
	end

	// a held result must not be overwritten
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result overwritten while stalled");

	// an accepted word enters the first stage
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		en && s_tvalid |=> v_s1)
		else $error("pipeline valid lost");

	// the last stage valid shifts into the output valid
	a_chain: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_c |=> m_tvalid)
		else $error("final stage valid dropped");

endmodule
